### hw/rtl/hiac_pkg.sv
`timescale 1ns / 1ps

package hiac_pkg;

	localparam int INDEX_W    = 64;
	localparam int AXIS_W     = 16;
	localparam int AXIS_N     = 4;
	localparam int DIMS_REG_W = 3;
	localparam int BITS_REG_W = 5;
	localparam int BITS_EFF_W = 6;
	localparam int WR_DATA_W  = 5;
	localparam int WR_INDEX_W = 1;

	localparam logic [WR_INDEX_W-1:0] REG_NUM_DIMS      = 1'b0;
	localparam logic [WR_INDEX_W-1:0] REG_BITS_PER_AXIS = 1'b1;

	localparam logic [DIMS_REG_W-1:0] NUM_DIMS_RST      = 3'd2;
	localparam logic [BITS_REG_W-1:0] BITS_PER_AXIS_RST = 5'd16;
	localparam logic [DIMS_REG_W-1:0] MIN_DIMS          = 3'd2;

	typedef enum logic {
		CMD_TO_AXES  = 1'b0,
		CMD_TO_INDEX = 1'b1
	} cmd_t;

	// effective (clamped) configuration seen by every stage
	typedef struct packed {
		logic [DIMS_REG_W-1:0] dims;
		logic [BITS_EFF_W-1:0] bits;
	} cfg_t;

endpackage

### hw/rtl/hiac_front.sv
`timescale 1ns / 1ps

module hiac_front
	import hiac_pkg::*;
#(
	parameter int MAX_DIMS = 4,
	parameter int W        = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cfg_t                                 cfg,
	input  logic                                 valid,
	input  cmd_t                                 cmd,
	input  logic [INDEX_W-1:0]                   index_in,
	input  logic [AXIS_N-1:0][AXIS_W-1:0]        axis_in,
	input  logic                                 take,
	output logic                                 rdy,
	output logic                                 vld_s1,
	output cmd_t                                 cmd_s1,
	output logic [MAX_DIMS-1:0][W-1:0]           x_s1
);

	logic [MAX_DIMS-1:0][W-1:0] xd;
	logic [MAX_DIMS-1:0][W-1:0] xg;
	logic [MAX_DIMS-1:0][W-1:0] xa;
	logic [MAX_DIMS-1:0][W-1:0] xn;
	logic [W-1:0]               top;
	logic [W-1:0]               mask;
	int                         pos;

	// de-interleave, gray decode, or mask the coordinates
	always_comb begin
		xd   = '0;
		xg   = '0;
		xa   = '0;
		top  = '0;
		pos  = 0;
		mask = ~({W{1'b1}} << cfg.bits);
		for (int dv = 2; dv <= MAX_DIMS; dv++) begin
			if (cfg.dims == DIMS_REG_W'(dv)) begin
				for (int k = 0; k < dv; k++) begin
					for (int i = 0; i < W; i++) begin
						pos = dv * i + (dv - 1 - k);
						if (pos < INDEX_W) begin
							xd[k][i] = index_in[pos[5:0]];
						end
					end
				end
			end
		end
		for (int k = 0; k < MAX_DIMS; k++) begin
			xd[k] = xd[k] & mask;
			if (DIMS_REG_W'(k + 1) == cfg.dims) begin
				top = xd[k];
			end
		end
		xg[0] = xd[0] ^ (top >> 1);
		for (int k = 1; k < MAX_DIMS; k++) begin
			if (DIMS_REG_W'(k) < cfg.dims) begin
				xg[k] = xd[k] ^ xd[k-1];
			end
		end
		for (int k = 0; k < MAX_DIMS; k++) begin
			if (DIMS_REG_W'(k) < cfg.dims) begin
				xa[k] = W'(axis_in[k]) & mask;
			end
		end
		xn = (cmd == CMD_TO_AXES) ? xg : xa;
	end

	assign rdy = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy) begin
			vld_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && valid) begin
			cmd_s1 <= cmd;
			x_s1   <= xn;
		end
	end

endmodule

### hw/rtl/hiac_cell.sv
`timescale 1ns / 1ps

module hiac_cell
	import hiac_pkg::*;
#(
	parameter int MAX_DIMS = 4,
	parameter int W        = 16,
	parameter int STAGE    = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       vld_i,
	input  cmd_t                       cmd_i,
	input  logic [MAX_DIMS-1:0][W-1:0] x_i,
	input  logic                       take,
	output logic                       rdy,
	output logic                       vld_q,
	output cmd_t                       cmd_q,
	output logic [MAX_DIMS-1:0][W-1:0] x_q
);

	logic [BITS_EFF_W-1:0]      lvl;
	logic                       active;
	logic [W-1:0]               q;
	logic [W-1:0]               p;
	logic [W-1:0]               t;
	logic [MAX_DIMS-1:0][W-1:0] x;

	// one bit level of the undo passes: ascending levels for decode, descending for encode
	always_comb begin
		lvl    = (cmd_i == CMD_TO_AXES) ? BITS_EFF_W'(STAGE + 1)
		                                : cfg.bits - BITS_EFF_W'(STAGE + 1);
		active = cfg.bits >= BITS_EFF_W'(STAGE + 2);
		q      = W'(1) << lvl;
		p      = q - W'(1);
		t      = '0;
		x      = x_i;
		if (active) begin
			if (cmd_i == CMD_TO_AXES) begin
				for (int k = MAX_DIMS - 1; k >= 0; k--) begin
					if (DIMS_REG_W'(k) < cfg.dims) begin
						if (|(x[k] & q)) begin
							x[0] = x[0] ^ p;
						end else begin
							t    = (x[0] ^ x[k]) & p;
							x[0] = x[0] ^ t;
							x[k] = x[k] ^ t;
						end
					end
				end
			end else begin
				for (int k = 0; k < MAX_DIMS; k++) begin
					if (DIMS_REG_W'(k) < cfg.dims) begin
						if (|(x[k] & q)) begin
							x[0] = x[0] ^ p;
						end else begin
							t    = (x[0] ^ x[k]) & p;
							x[0] = x[0] ^ t;
							x[k] = x[k] ^ t;
						end
					end
				end
			end
		end
	end

	assign rdy = !vld_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rdy) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && vld_i) begin
			cmd_q <= cmd_i;
			x_q   <= x;
		end
	end

endmodule

### hw/rtl/hiac_back.sv
`timescale 1ns / 1ps

module hiac_back
	import hiac_pkg::*;
#(
	parameter int MAX_DIMS = 4,
	parameter int W        = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          vld_i,
	input  cmd_t                          cmd_i,
	input  logic [MAX_DIMS-1:0][W-1:0]    x_i,
	input  logic                          stall,
	output logic                          rdy,
	output logic                          vld_q,
	output logic [INDEX_W-1:0]            index_q,
	output logic [AXIS_N-1:0][AXIS_W-1:0] axis_q
);

	logic [MAX_DIMS-1:0][W-1:0] y;
	logic [MAX_DIMS-1:0][W-1:0] z;
	logic [W-1:0]               top;
	logic [W-1:0]               t;
	logic [INDEX_W-1:0]         idx;
	logic [AXIS_N-1:0][AXIS_W-1:0] ax;
	int                         pos;

	// gray encode, fold the top axis back in, interleave; for decode, pass the axes out instead
	always_comb begin
		y    = '0;
		z    = '0;
		top  = '0;
		t    = '0;
		idx  = '0;
		ax   = '0;
		pos  = 0;
		y[0] = x_i[0];
		for (int k = 1; k < MAX_DIMS; k++) begin
			y[k] = y[k-1] ^ x_i[k];
		end
		for (int k = 0; k < MAX_DIMS; k++) begin
			if (DIMS_REG_W'(k + 1) == cfg.dims) begin
				top = y[k];
			end
		end
		for (int m = 0; m < W; m++) begin
			t[m] = ^(top >> (m + 1));
		end
		for (int k = 0; k < MAX_DIMS; k++) begin
			z[k] = y[k] ^ t;
		end
		for (int dv = 2; dv <= MAX_DIMS; dv++) begin
			if (cfg.dims == DIMS_REG_W'(dv)) begin
				for (int i = 0; i < W; i++) begin
					for (int j = 0; j < dv; j++) begin
						pos = dv * i + j;
						if (pos < INDEX_W) begin
							idx[pos[5:0]] = z[dv-1-j][i];
						end
					end
				end
			end
		end
		for (int k = 0; k < MAX_DIMS; k++) begin
			if (DIMS_REG_W'(k) < cfg.dims) begin
				ax[k] = AXIS_W'(x_i[k]);
			end
		end
		if (cmd_i == CMD_TO_AXES) begin
			idx = '0;
		end else begin
			ax = '0;
		end
	end

	assign rdy = !vld_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rdy) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && vld_i) begin
			index_q <= idx;
			axis_q  <= ax;
		end
	end

endmodule

### hw/rtl/hilbert_index_axes_convert_top.sv
`timescale 1ns / 1ps

// channel   dir   handshake            word
// req       in    req_valid/req_stall  command, index_in, axis_in_0..3
// rsp       out   rsp_valid/rsp_stall  index_out, axis_out_0..3
// cfg       in    wr_en                wr_index, wr_data
//
// one word in and one word out per cycle when rsp is not stalled
// the pipeline is an input stage, MAX_BITS - 1 bit level cells (one cell if MAX_BITS is 1) and an output register
// each cell does one level of the undo passes; the chain length sets the latency
// arst_n clears the valid bits and sets num_dims to 2, bits_per_axis to 16
// a stall only holds stages that are full; bubbles keep moving forward

module hilbert_index_axes_convert_top
	import hiac_pkg::*;
#(
	parameter int MAX_DIMS = 4,
	parameter int MAX_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [WR_INDEX_W-1:0] wr_index,
	input  logic [WR_DATA_W-1:0]  wr_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  command,
	input  logic [INDEX_W-1:0]    index_in,
	input  logic [AXIS_W-1:0]     axis_in_0,
	input  logic [AXIS_W-1:0]     axis_in_1,
	input  logic [AXIS_W-1:0]     axis_in_2,
	input  logic [AXIS_W-1:0]     axis_in_3,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic [INDEX_W-1:0]    index_out,
	output logic [AXIS_W-1:0]     axis_out_0,
	output logic [AXIS_W-1:0]     axis_out_1,
	output logic [AXIS_W-1:0]     axis_out_2,
	output logic [AXIS_W-1:0]     axis_out_3
);

	localparam int W     = MAX_BITS;
	localparam int NCELL = (MAX_BITS > 1) ? MAX_BITS - 1 : 1;

	logic [DIMS_REG_W-1:0]            num_dims_q;
	logic [BITS_REG_W-1:0]            bits_per_axis_q;
	cfg_t                             cfg;
	logic [AXIS_N-1:0][AXIS_W-1:0]    axis_in;
	logic [AXIS_N-1:0][AXIS_W-1:0]    axis_out;
	logic                             front_rdy;
	logic [NCELL:0]                   vld_c;
	cmd_t                             cmd_c [NCELL+1];
	logic [NCELL:0][MAX_DIMS-1:0][W-1:0] x_c;
	logic [NCELL:0]                   take_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q      <= NUM_DIMS_RST;
			bits_per_axis_q <= BITS_PER_AXIS_RST;
		end else if (wr_en) begin
			if (wr_index == REG_NUM_DIMS) begin
				num_dims_q <= wr_data[DIMS_REG_W-1:0];
			end else if (wr_index == REG_BITS_PER_AXIS) begin
				bits_per_axis_q <= wr_data[BITS_REG_W-1:0];
			end
		end
	end

	// saturate the registers to the supported range
	always_comb begin
		cfg.dims = num_dims_q;
		if (num_dims_q < MIN_DIMS) begin
			cfg.dims = MIN_DIMS;
		end else if (num_dims_q > DIMS_REG_W'(MAX_DIMS)) begin
			cfg.dims = DIMS_REG_W'(MAX_DIMS);
		end
		cfg.bits = BITS_EFF_W'(bits_per_axis_q);
		if (cfg.bits == '0) begin
			cfg.bits = BITS_EFF_W'(1);
		end else if (cfg.bits > BITS_EFF_W'(MAX_BITS)) begin
			cfg.bits = BITS_EFF_W'(MAX_BITS);
		end
	end

	assign axis_in   = {axis_in_3, axis_in_2, axis_in_1, axis_in_0};
	assign req_stall = !front_rdy;

	hiac_front #(
		.MAX_DIMS (MAX_DIMS),
		.W        (W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid    (req_valid),
		.cmd      (cmd_t'(command)),
		.index_in (index_in),
		.axis_in  (axis_in),
		.take     (take_c[0]),
		.rdy      (front_rdy),
		.vld_s1   (vld_c[0]),
		.cmd_s1   (cmd_c[0]),
		.x_s1     (x_c[0])
	);

	for (genvar n = 0; n < NCELL; n++) begin : g_cell
		hiac_cell #(
			.MAX_DIMS (MAX_DIMS),
			.W        (W),
			.STAGE    (n)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg),
			.vld_i  (vld_c[n]),
			.cmd_i  (cmd_c[n]),
			.x_i    (x_c[n]),
			.take   (take_c[n+1]),
			.rdy    (take_c[n]),
			.vld_q  (vld_c[n+1]),
			.cmd_q  (cmd_c[n+1]),
			.x_q    (x_c[n+1])
		);
	end

	hiac_back #(
		.MAX_DIMS (MAX_DIMS),
		.W        (W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.vld_i   (vld_c[NCELL]),
		.cmd_i   (cmd_c[NCELL]),
		.x_i     (x_c[NCELL]),
		.stall   (rsp_stall),
		.rdy     (take_c[NCELL]),
		.vld_q   (rsp_valid),
		.index_q (index_out),
		.axis_q  (axis_out)
	);

	assign axis_out_0 = axis_out[0];
	assign axis_out_1 = axis_out[1];
	assign axis_out_2 = axis_out[2];
	assign axis_out_3 = axis_out[3];

endmodule
